FILE: rtl/sdcs_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sdcs_pkg
// Shared types and codes of the SD card command sequencer.
// ----------------------------------------------------------------------------
package sdcs_pkg;

  localparam int unsigned BlockShift = 9;  // 512-byte blocks
  localparam logic [31:0] BlockBytes = 32'd512;

  // event modes
  localparam logic [1:0] ModeStart    = 2'd0;
  localparam logic [1:0] ModeComplete = 2'd1;
  localparam logic [1:0] ModeRead     = 2'd2;

  // expected response kinds
  localparam logic [2:0] RespNone = 3'd0;
  localparam logic [2:0] RespR1   = 3'd1;
  localparam logic [2:0] RespR1b  = 3'd2;
  localparam logic [2:0] RespR2   = 3'd3;
  localparam logic [2:0] RespR3   = 3'd4;
  localparam logic [2:0] RespR6   = 3'd5;
  localparam logic [2:0] RespR7   = 3'd6;

  // status codes
  localparam logic [2:0] StBusy     = 3'd0;
  localparam logic [2:0] StReady    = 3'd1;
  localparam logic [2:0] StInitFail = 3'd2;
  localparam logic [2:0] StReadDone = 3'd3;
  localparam logic [2:0] StReadFail = 3'd4;
  localparam logic [2:0] StRejected = 3'd5;

  // command indexes
  localparam logic [5:0] CmdGoIdle     = 6'd0;
  localparam logic [5:0] CmdAllCid     = 6'd2;
  localparam logic [5:0] CmdRelAddr    = 6'd3;
  localparam logic [5:0] CmdBusWidth   = 6'd6;
  localparam logic [5:0] CmdSelect     = 6'd7;
  localparam logic [5:0] CmdIfCond     = 6'd8;
  localparam logic [5:0] CmdVoltSwitch = 6'd11;
  localparam logic [5:0] CmdBlockLen   = 6'd16;
  localparam logic [5:0] CmdReadSingle = 6'd17;
  localparam logic [5:0] CmdReadMulti  = 6'd18;
  localparam logic [5:0] CmdBlockCount = 6'd23;
  localparam logic [5:0] CmdOpCond     = 6'd41;
  localparam logic [5:0] CmdAppCmd     = 6'd55;

  // configuration register indexes
  localparam logic [1:0] RegEchoPattern = 2'd0;
  localparam logic [1:0] RegRetryLimit  = 2'd1;
  localparam logic [1:0] RegVoltWindow  = 2'd2;
  localparam logic [1:0] RegBusWidth    = 2'd3;

  typedef struct packed {
    logic [7:0]  echo_pattern;
    logic [7:0]  retry_limit;
    logic [15:0] voltage_window;
    logic [1:0]  bus_width_code;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  mode;
    logic        cmd_ok;
    logic [31:0] resp_word;
    logic [31:0] first_block;
    logic [15:0] block_count;
  } item_t;

  typedef struct packed {
    logic        cmd_valid;
    logic [5:0]  cmd_index;
    logic [31:0] cmd_arg;
    logic [2:0]  resp_kind;
    logic [7:0]  delay_ms;
    logic        fast_clock;
    logic [15:0] data_blocks;
    logic [2:0]  status;
    logic        high_capacity;
  } result_t;

endpackage
`default_nettype wire

FILE: rtl/sdcs_cfg_regs.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sdcs_cfg_regs
// APB configuration registers of the SD card command sequencer.
// ----------------------------------------------------------------------------
module sdcs_cfg_regs (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               psel_i,
  input  wire logic               penable_i,
  input  wire logic               pwrite_i,
  input  wire logic [3:0]         paddr_i,
  input  wire logic [31:0]        pwdata_i,
  output logic      [31:0]        prdata_o,
  output sdcs_pkg::cfg_t          cfg_o
);
  import sdcs_pkg::*;

  cfg_t       cfg_q, cfg_d;
  logic       wr_en;
  logic [1:0] reg_sel;

  assign wr_en   = psel_i & penable_i & pwrite_i;
  assign reg_sel = paddr_i[3:2];

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (reg_sel)
        RegEchoPattern: cfg_d.echo_pattern   = pwdata_i[7:0];
        RegRetryLimit:  cfg_d.retry_limit    = pwdata_i[7:0];
        RegVoltWindow:  cfg_d.voltage_window = pwdata_i[15:0];
        RegBusWidth:    cfg_d.bus_width_code = pwdata_i[1:0];
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.echo_pattern   <= 8'hAA;
      cfg_q.retry_limit    <= 8'd50;
      cfg_q.voltage_window <= 16'hFF80;
      cfg_q.bus_width_code <= 2'd2;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  always_comb begin
    unique case (reg_sel)
      RegEchoPattern: prdata_o = {24'd0, cfg_q.echo_pattern};
      RegRetryLimit:  prdata_o = {24'd0, cfg_q.retry_limit};
      RegVoltWindow:  prdata_o = {16'd0, cfg_q.voltage_window};
      RegBusWidth:    prdata_o = {30'd0, cfg_q.bus_width_code};
      default:        prdata_o = 32'd0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule
`default_nettype wire

FILE: rtl/sdcs_engine.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sdcs_engine
// Sequencer state and next-command logic; one event per enabled cycle.
// ----------------------------------------------------------------------------
module sdcs_engine (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           en_i,
  input  sdcs_pkg::item_t     item_i,
  input  sdcs_pkg::cfg_t      cfg_i,
  output sdcs_pkg::result_t   res_o
);
  import sdcs_pkg::*;

  localparam logic [4:0] PhIdle   = 5'd0;
  localparam logic [4:0] PhCmd0   = 5'd1;
  localparam logic [4:0] PhCmd8   = 5'd2;
  localparam logic [4:0] PhPoll55 = 5'd3;
  localparam logic [4:0] PhAcmd41 = 5'd4;
  localparam logic [4:0] PhCmd11  = 5'd5;
  localparam logic [4:0] PhCmd2   = 5'd6;
  localparam logic [4:0] PhCmd3   = 5'd7;
  localparam logic [4:0] PhCmd7   = 5'd8;
  localparam logic [4:0] PhApp55  = 5'd9;
  localparam logic [4:0] PhAcmd6  = 5'd10;
  localparam logic [4:0] PhCmd16  = 5'd11;
  localparam logic [4:0] PhReady  = 5'd12;
  localparam logic [4:0] PhFailed = 5'd13;
  localparam logic [4:0] PhRd23   = 5'd14;
  localparam logic [4:0] PhRd18   = 5'd15;
  localparam logic [4:0] PhRd17   = 5'd16;

  localparam logic [7:0] DelayReset = 8'd100;
  localparam logic [7:0] DelayPoll  = 8'd200;

  logic [4:0]  phase_q, phase_d;
  logic [7:0]  attempts_q, attempts_d;
  logic [15:0] card_addr_q, card_addr_d;
  logic        sdhc_q, sdhc_d;
  logic        multi_q, multi_d;
  logic [31:0] next_block_q, next_block_d;
  logic [15:0] blocks_left_q, blocks_left_d;

  logic [7:0]  b0, b1, b2, b3;
  logic [7:0]  att_inc;
  logic [31:0] blk_inc;
  logic [15:0] left_dec;
  result_t     res;

  function automatic result_t issue(input logic [5:0] idx, input logic [31:0] arg,
                                    input logic [2:0] kind, input logic [7:0] dly,
                                    input logic fast, input logic [15:0] blocks);
    result_t r;
    r             = '0;
    r.cmd_valid   = 1'b1;
    r.cmd_index   = idx;
    r.cmd_arg     = arg;
    r.resp_kind   = kind;
    r.delay_ms    = dly;
    r.fast_clock  = fast;
    r.data_blocks = blocks;
    r.status      = StBusy;
    return r;
  endfunction

  function automatic logic [31:0] addr_of(input logic hc, input logic [31:0] blk);
    return hc ? blk : (blk << BlockShift);
  endfunction

  assign b0       = item_i.resp_word[7:0];
  assign b1       = item_i.resp_word[15:8];
  assign b2       = item_i.resp_word[23:16];
  assign b3       = item_i.resp_word[31:24];
  assign att_inc  = attempts_q + 8'd1;
  assign blk_inc  = next_block_q + 32'd1;
  assign left_dec = blocks_left_q - 16'd1;

  always_comb begin
    phase_d       = phase_q;
    attempts_d    = attempts_q;
    card_addr_d   = card_addr_q;
    sdhc_d        = sdhc_q;
    multi_d       = multi_q;
    next_block_d  = next_block_q;
    blocks_left_d = blocks_left_q;
    res           = '0;

    priority if (item_i.mode == ModeStart) begin
      card_addr_d = 16'd0;
      sdhc_d      = 1'b0;
      multi_d     = 1'b0;
      attempts_d  = 8'd0;
      phase_d     = PhCmd0;
      res         = issue(CmdGoIdle, 32'd0, RespNone, DelayReset, 1'b0, 16'd0);
    end else if (item_i.mode == ModeComplete) begin
      unique case (phase_q)
        PhCmd0: begin
          if (!item_i.cmd_ok) begin
            phase_d = PhFailed; res.status = StInitFail;
          end else begin
            phase_d = PhCmd8;
            res = issue(CmdIfCond, {23'd0, 1'b1, cfg_i.echo_pattern}, RespR7,
                        8'd0, 1'b0, 16'd0);
          end
        end
        PhCmd8: begin
          if (!item_i.cmd_ok || b1 != 8'd1 || b0 != cfg_i.echo_pattern) begin
            phase_d = PhFailed; res.status = StInitFail;
          end else begin
            attempts_d = 8'd0;
            phase_d    = PhPoll55;
            res = issue(CmdAppCmd, {card_addr_q, 16'd0}, RespR1, 8'd0, 1'b0, 16'd0);
          end
        end
        PhPoll55, PhAcmd41: begin
          priority if (!item_i.cmd_ok || (phase_q == PhAcmd41 && b2 == 8'hFF
                                          && b1[7] && !b3[7])) begin
            attempts_d = att_inc;
            if (att_inc >= cfg_i.retry_limit || att_inc == 8'd0) begin
              phase_d = PhFailed; res.status = StInitFail;
            end else begin
              phase_d = PhPoll55;
              res = issue(CmdAppCmd, {card_addr_q, 16'd0}, RespR1, DelayPoll,
                          1'b0, 16'd0);
            end
          end else if (phase_q == PhPoll55) begin
            phase_d = PhAcmd41;
            res = issue(CmdOpCond, {2'b01, 14'd0, cfg_i.voltage_window}, RespR3,
                        8'd0, 1'b0, 16'd0);
          end else if (!b1[7] || b2 != 8'hFF) begin
            phase_d = PhFailed; res.status = StInitFail;
          end else begin
            sdhc_d = b3[6];
            if (b3[0]) begin
              phase_d = PhCmd11;
              res = issue(CmdVoltSwitch, 32'd0, RespR1, 8'd0, 1'b0, 16'd0);
            end else begin
              phase_d = PhCmd2;
              res = issue(CmdAllCid, 32'd0, RespR2, 8'd0, 1'b0, 16'd0);
            end
          end
        end
        PhCmd11, PhCmd2, PhCmd3, PhCmd7, PhApp55, PhAcmd6, PhCmd16: begin
          if (!item_i.cmd_ok) begin
            phase_d = PhFailed; res.status = StInitFail;
          end else begin
            unique case (phase_q)
              PhCmd11: begin
                phase_d = PhCmd2;
                res = issue(CmdAllCid, 32'd0, RespR2, 8'd0, 1'b0, 16'd0);
              end
              PhCmd2: begin
                phase_d = PhCmd3;
                res = issue(CmdRelAddr, 32'd0, RespR6, 8'd0, 1'b0, 16'd0);
              end
              PhCmd3: begin
                card_addr_d = item_i.resp_word[31:16];
                phase_d     = PhCmd7;
                res = issue(CmdSelect, {item_i.resp_word[31:16], 16'd0}, RespR1b,
                            8'd0, 1'b1, 16'd0);
              end
              PhCmd7: begin
                phase_d = PhApp55;
                res = issue(CmdAppCmd, {card_addr_q, 16'd0}, RespR1, DelayPoll,
                            1'b0, 16'd0);
              end
              PhApp55: begin
                phase_d = PhAcmd6;
                res = issue(CmdBusWidth, {30'd0, cfg_i.bus_width_code}, RespR1,
                            8'd0, 1'b0, 16'd0);
              end
              PhAcmd6: begin
                if (!sdhc_q) begin
                  phase_d = PhCmd16;
                  res = issue(CmdBlockLen, BlockBytes, RespR1, 8'd0, 1'b0, 16'd0);
                end else begin
                  multi_d = 1'b1; phase_d = PhReady; res.status = StReady;
                end
              end
              default: begin
                multi_d = 1'b1; phase_d = PhReady; res.status = StReady;
              end
            endcase
          end
        end
        PhRd23: begin
          if (!item_i.cmd_ok) begin
            multi_d = 1'b0;
            phase_d = PhRd17;
            res = issue(CmdReadSingle, addr_of(sdhc_q, next_block_q), RespR1,
                        8'd0, 1'b0, 16'd1);
          end else begin
            phase_d = PhRd18;
            res = issue(CmdReadMulti, addr_of(sdhc_q, next_block_q), RespR1,
                        8'd0, 1'b0, blocks_left_q);
          end
        end
        PhRd18: begin
          phase_d    = PhReady;
          res.status = item_i.cmd_ok ? StReadDone : StReadFail;
        end
        PhRd17: begin
          if (!item_i.cmd_ok) begin
            phase_d = PhReady; res.status = StReadFail;
          end else begin
            next_block_d  = blk_inc;
            blocks_left_d = left_dec;
            if (left_dec == 16'd0) begin
              phase_d = PhReady; res.status = StReadDone;
            end else begin
              res = issue(CmdReadSingle, addr_of(sdhc_q, blk_inc), RespR1,
                          8'd0, 1'b0, 16'd1);
            end
          end
        end
        default: res.status = StRejected;
      endcase
    end else if (item_i.mode == ModeRead && phase_q == PhReady
                 && item_i.block_count != 16'd0) begin
      next_block_d  = item_i.first_block;
      blocks_left_d = item_i.block_count;
      if (item_i.block_count == 16'd1 || !multi_q) begin
        phase_d = PhRd17;
        res = issue(CmdReadSingle, addr_of(sdhc_q, item_i.first_block), RespR1,
                    8'd0, 1'b0, 16'd1);
      end else begin
        phase_d = PhRd23;
        res = issue(CmdBlockCount, {16'd0, item_i.block_count}, RespR1,
                    8'd0, 1'b0, 16'd0);
      end
    end else begin
      res.status = StRejected;
    end

    res.high_capacity = sdhc_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= PhIdle;
      attempts_q    <= 8'd0;
      card_addr_q   <= 16'd0;
      sdhc_q        <= 1'b0;
      multi_q       <= 1'b0;
      next_block_q  <= 32'd0;
      blocks_left_q <= 16'd0;
    end else if (en_i) begin
      phase_q       <= phase_d;
      attempts_q    <= attempts_d;
      card_addr_q   <= card_addr_d;
      sdhc_q        <= sdhc_d;
      multi_q       <= multi_d;
      next_block_q  <= next_block_d;
      blocks_left_q <= blocks_left_d;
    end
  end

  assign res_o = res;

  a_start_enters_cmd0: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en_i && item_i.mode == ModeStart |=> phase_q == PhCmd0)
    else $error("start event did not enter CMD0 phase");

  a_fail_parks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en_i && res.status == StInitFail |=> phase_q == PhFailed)
    else $error("init failure did not park the sequencer");

  a_cmd_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en_i && res.cmd_valid |-> res.status == StBusy)
    else $error("command issued with a final status");

  a_single_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en_i && phase_q == PhRd17 && item_i.mode == ModeComplete && item_i.cmd_ok
    |=> next_block_q == $past(next_block_q) + 32'd1)
    else $error("single-block read did not advance block number");

endmodule
`default_nettype wire

FILE: rtl/sd_card_command_sequencer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sd_card_command_sequencer
// Host-side SD card initialization and block-read command sequencer.
// ----------------------------------------------------------------------------
// Events enter on the s_axis channel: tuser carries the mode (start, command
// completed, read request), tdata the completion flag, the short response and
// the read request. Every event yields exactly one result transfer on the
// m_axis channel: the command to issue now (if any) with its argument,
// expected response kind, pre-issue delay, fast-clock flag and data block
// count, plus a status code and the high-capacity flag.
// An event accepted on s_axis is loaded into the input register; the result
// register is then written from the next-command logic once it is empty or
// m_axis_tready is high. One event per cycle is sustained while the receiver
// holds m_axis_tready high; the state update is a single combinational pass.
// Reset clears the sequencer to idle, not initialized, and loads the
// configuration registers with their defaults. A receiver stall holds the
// result register; s_axis_tready drops once the input register is also full.
// User must write configuration registers over APB only while idle; unchecked.
// ----------------------------------------------------------------------------
module sd_card_command_sequencer (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // tdata: cmd_ok[0], resp_word[32:1], first_block[64:33], block_count[80:65]
  input  wire logic [87:0] s_axis_tdata,
  // tuser: mode[1:0]
  input  wire logic [1:0]  s_axis_tuser,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // tdata: cmd_valid[0], cmd_index[6:1], cmd_arg[38:7], resp_kind[41:39],
  //        delay_ms[49:42], fast_clock[50], data_blocks[66:51],
  //        status[69:67], high_capacity[70]
  output logic [71:0]      m_axis_tdata,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import sdcs_pkg::*;

  item_t   in_q, in_d;
  logic    in_valid_q, in_valid_d;
  result_t out_q, res;
  logic    out_valid_q, out_valid_d;
  logic    advance;
  logic    s_xfer;
  cfg_t    cfg;

  assign advance       = in_valid_q & (~out_valid_q | m_axis_tready);
  assign s_axis_tready = ~in_valid_q | advance;
  assign s_xfer        = s_axis_tvalid & s_axis_tready;

  always_comb begin
    in_d.mode        = s_axis_tuser;
    in_d.cmd_ok      = s_axis_tdata[0];
    in_d.resp_word   = s_axis_tdata[32:1];
    in_d.first_block = s_axis_tdata[64:33];
    in_d.block_count = s_axis_tdata[80:65];
  end

  always_comb begin
    in_valid_d = in_valid_q;
    if (s_xfer) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_xfer) begin
      in_q <= in_d;
    end
    if (advance) begin
      out_q <= res;
    end
  end

  sdcs_cfg_regs u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel_i    (psel),
    .penable_i (penable),
    .pwrite_i  (pwrite),
    .paddr_i   (paddr),
    .pwdata_i  (pwdata),
    .prdata_o  (prdata),
    .cfg_o     (cfg)
  );

  sdcs_engine u_engine (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (advance),
    .item_i (in_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  assign pready        = 1'b1;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, out_q.high_capacity, out_q.status, out_q.data_blocks,
                          out_q.fast_clock, out_q.delay_ms, out_q.resp_kind,
                          out_q.cmd_arg, out_q.cmd_index, out_q.cmd_valid};

endmodule
`default_nettype wire
